### src/unique_sorted_table_search_assert.svh
// Assertion macros for the sorted table search block.
`ifndef UNIQUE_SORTED_TABLE_SEARCH_ASSERT_SVH
`define UNIQUE_SORTED_TABLE_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UST_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define UST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UST_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### src/ust_pkg.sv
`default_nettype none

package ust_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int KEY_W    = 32;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 4;
  localparam int CNT_W    = 5;

  // action codes; the high bit alone selects clear
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
  localparam int               CLEAR_BIT  = 1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTREADY  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

  // per-cell compare flags
  typedef struct packed {
    logic less;
    logic match;
  } cell_flags_t;

endpackage

`default_nettype wire

### src/ust_req_if.sv
`default_nettype none

interface ust_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [ust_pkg::ACT_W-1:0]             action;
  logic signed [ust_pkg::KEY_W-1:0]      key_value;

  modport source (output valid, output action, output key_value, input ready);
  modport sink   (input valid, input action, input key_value, output ready);
endinterface

`default_nettype wire

### src/ust_rsp_if.sv
`default_nettype none

interface ust_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ust_pkg::STATUS_W-1:0]   status;
  logic [ust_pkg::POS_W-1:0]      position;
  logic                           odd_position;
  logic [ust_pkg::CNT_W-1:0]      stored_count;

  modport source (output valid, output status, output position, output odd_position,
                  output stored_count, input ready);
  modport sink   (input valid, input status, input position, input odd_position,
                  input stored_count, output ready);
endinterface

`default_nettype wire

### src/ust_cell.sv
`default_nettype none

// One slot of the sorted row. Compares its key with the broadcast key and,
// on an insert, either keeps its key, takes the new key or takes its left
// neighbor's key.
module ust_cell (
  input  wire                                   clk,
  input  wire                                   occupied,
  input  wire                                   shift_en,
  input  wire logic signed [ust_pkg::KEY_W-1:0] key_in,
  input  wire                                   prev_less,
  input  wire logic signed [ust_pkg::KEY_W-1:0] prev_key,
  output ust_pkg::cell_flags_t                  flags,
  output logic signed [ust_pkg::KEY_W-1:0]      key_out
);

  logic signed [ust_pkg::KEY_W-1:0] stored;

  // compare against the broadcast key
  always_comb begin
    flags.less  = occupied && (stored < key_in);
    flags.match = occupied && (stored == key_in);
  end

  assign key_out = stored;

  // insert: smaller keys stay, the first larger slot takes the key, the rest shift right
  always_ff @(posedge clk) begin
    if (shift_en && !flags.less) begin
      stored <= prev_less ? key_in : prev_key;
    end
  end

endmodule

`default_nettype wire

### src/unique_sorted_table_search.sv
// Sorted unique key table with search.
// request channel: action (load, search, clear) and a signed 32-bit key.
// response channel: status, position, odd_position and stored_count, one
// item per request item, in order.
// The response is registered and valid in the cycle after the request is accepted.
// Throughput: one item per cycle unless the receiver stalls; every slot
// of the cell row compares its key with the incoming key in the same
// cycle and an insert shifts the row in one step.
// A search answers only once DEPTH keys are held; before that it returns
// not ready. A load into a full table returns full; a held key, duplicate.
// Reset empties the table (stored count zero) and drops any pending
// response. Key storage is not cleared; empty slots are never compared.
// When the receiver stalls, the response register holds its item and
// request ready stays high only if that register is being emptied in the
// same cycle, so no item is lost or repeated.
`default_nettype none
`include "unique_sorted_table_search_assert.svh"

module unique_sorted_table_search #(
  parameter int DEPTH = ust_pkg::DEPTH_DEFAULT
) (
  input  wire     clk,
  input  wire     rst,
  ust_req_if.sink   request,
  ust_rsp_if.source response
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [CW-1:0]                    count;
  logic [CW-1:0]                    count_next;
  logic                             rsp_valid;
  logic                             accept;
  logic                             is_clear;
  logic                             is_load;
  logic                             full;
  logic                             dup;
  logic [IW-1:0]                    hit_idx;
  logic [ust_pkg::STATUS_W-1:0]     status_next;
  logic [IW-1:0]                    pos_next;
  logic [CW+ust_pkg::CNT_W-1:0]     count_wide;
  logic [IW+ust_pkg::POS_W-1:0]     pos_wide;
  logic                             shift_en;
  ust_pkg::cell_flags_t             flags [DEPTH];
  logic [DEPTH:0]                   less_chain;
  logic signed [ust_pkg::KEY_W-1:0] key_chain [DEPTH+1];

  // handshake
  assign request.ready  = !rsp_valid || response.ready;
  assign accept         = request.valid && request.ready;
  assign response.valid = rsp_valid;

  // decode
  assign is_clear = request.action[ust_pkg::CLEAR_BIT];
  assign is_load  = (request.action == ust_pkg::ACT_LOAD);
  assign full     = (count == CW'(DEPTH));

  // cell row
  assign shift_en      = accept && is_load && !full && !dup;
  assign less_chain[0] = 1'b1;
  assign key_chain[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ust_cell u_cell (
      .clk       (clk),
      .occupied  (CW'(i) < count),
      .shift_en  (shift_en),
      .key_in    (request.key_value),
      .prev_less (less_chain[i]),
      .prev_key  (key_chain[i]),
      .flags     (flags[i]),
      .key_out   (key_chain[i+1])
    );
    assign less_chain[i+1] = flags[i].less;
  end

  // match reduction; keys are unique so at most one cell hits
  always_comb begin
    dup     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (flags[i].match) begin
        dup     = 1'b1;
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // result and next count
  always_comb begin
    count_next  = count;
    pos_next    = '0;
    status_next = ust_pkg::ST_CLEARED;
    if (is_clear) begin
      count_next  = '0;
      status_next = ust_pkg::ST_CLEARED;
    end else if (is_load) begin
      if (full) begin
        status_next = ust_pkg::ST_FULL;
      end else if (dup) begin
        status_next = ust_pkg::ST_DUPLICATE;
      end else begin
        count_next  = count + CW'(1);
        status_next = ust_pkg::ST_STORED;
      end
    end else begin
      if (!full) begin
        status_next = ust_pkg::ST_NOTREADY;
      end else if (dup) begin
        status_next = ust_pkg::ST_FOUND;
        pos_next    = hit_idx;
      end else begin
        status_next = ust_pkg::ST_NOTFOUND;
      end
    end
  end

  assign count_wide = {{ust_pkg::CNT_W{1'b0}}, count_next};
  assign pos_wide   = {{ust_pkg::POS_W{1'b0}}, pos_next};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      response.status       <= status_next;
      response.position     <= pos_wide[ust_pkg::POS_W-1:0];
      response.odd_position <= pos_next[0];
      response.stored_count <= count_wide[ust_pkg::CNT_W-1:0];
    end
  end

  // checks
  `UST_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `UST_ASSERT_NEXT(a_store_incr, clk, rst, shift_en, count == $past(count) + CW'(1))
  `UST_ASSERT_NEXT(a_clear_empty, clk, rst, accept && is_clear, count == '0)
  `UST_ASSERT_IMPL(a_no_shift_full, clk, rst, full, !shift_en)
  `UST_ASSERT_IMPL(a_pos_zero, clk, rst, rsp_valid && response.status != ust_pkg::ST_FOUND, response.position == '0 && !response.odd_position)

endmodule

`default_nettype wire
